// ===== sv/jhmp_pkg.sv =====
// Package for the JPEG header marker parser: parse phases, record kinds, error codes.
// No dependencies.
package jhmp_pkg;

  typedef enum logic [4:0] {
    PH_SOI, PH_HUNT, PH_MARK, PH_SKIP_L1, PH_SKIP_L2, PH_SKIP, PH_HALT,
    PH_SOF_HDR, PH_SOF_CID, PH_SOF_SAMP, PH_SOF_TQ,
    PH_DQT_L1, PH_DQT_L2, PH_DQT_PT, PH_DQT_V8, PH_DQT_VH, PH_DQT_VL,
    PH_DHT_L1, PH_DHT_L2, PH_DHT_TC, PH_DHT_CNT, PH_DHT_SYM,
    PH_SOS_HDR, PH_SOS_CID, PH_SOS_TAB, PH_SOS_TAIL, PH_DRI
  } phase_e;

  localparam logic [3:0] KIND_HEIGHT     = 4'd0;
  localparam logic [3:0] KIND_WIDTH      = 4'd1;
  localparam logic [3:0] KIND_COMP_SAMP  = 4'd2;
  localparam logic [3:0] KIND_QUANT      = 4'd3;
  localparam logic [3:0] KIND_HUFF_CNT   = 4'd4;
  localparam logic [3:0] KIND_HUFF_SYM   = 4'd5;
  localparam logic [3:0] KIND_SCAN_COMP  = 4'd6;
  localparam logic [3:0] KIND_SCAN_CNT   = 4'd7;
  localparam logic [3:0] KIND_RESTART    = 4'd8;
  localparam logic [3:0] KIND_SCAN_START = 4'd9;
  localparam logic [3:0] KIND_ERROR      = 4'd10;

  localparam logic [2:0] ERR_NO_SOI     = 3'd1;
  localparam logic [2:0] ERR_COMPS      = 3'd2;
  localparam logic [2:0] ERR_QUANT_IDX  = 3'd3;
  localparam logic [2:0] ERR_PRECISION  = 3'd4;
  localparam logic [2:0] ERR_HUFF_IDX   = 3'd5;
  localparam logic [2:0] ERR_CLASS      = 3'd6;
  localparam logic [2:0] ERR_EOI_FIRST  = 3'd7;

  localparam logic [7:0] MRK_PREFIX = 8'hFF;
  localparam logic [7:0] MRK_SOI    = 8'hD8;
  localparam logic [7:0] MRK_SOF0   = 8'hC0;
  localparam logic [7:0] MRK_DQT    = 8'hDB;
  localparam logic [7:0] MRK_DHT    = 8'hC4;
  localparam logic [7:0] MRK_SOS    = 8'hDA;
  localparam logic [7:0] MRK_EOI    = 8'hD9;
  localparam logic [7:0] MRK_DRI    = 8'hDD;
  localparam logic [7:0] MRK_RST0   = 8'hD0;
  localparam logic [11:0] QUANT_ENTRIES = 12'd64;
  localparam logic [11:0] HUFF_COUNTS   = 12'd16;

  typedef struct packed {
    logic [3:0]  kind;
    logic [1:0]  component;
    logic        table_class;
    logic [1:0]  table_id;
    logic [11:0] entry_index;
    logic [15:0] value;
    logic [3:0]  h_factor;
    logic [3:0]  v_factor;
    logic [3:0]  dc_table;
    logic [3:0]  ac_table;
    logic [2:0]  error_code;
    logic [31:0] stream_offset;
  } rec_t;

endpackage

// ===== sv/jhmp_core.sv =====
// Parser state and per-byte next-state/record logic.
// Depends on jhmp_pkg.
module jhmp_core import jhmp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       rec_valid_o,
  output rec_t       rec_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] seg_q, seg_d;
  logic [11:0] cnt_q, cnt_d;
  logic [7:0]  loop_q, loop_d;
  logic [11:0] sym_q, sym_d;
  logic        cls_q, cls_d;
  logic [1:0]  tbl_q, tbl_d;
  logic        wide_q, wide_d;
  logic [7:0]  hi_q, hi_d;
  logic [7:0]  comp_q, comp_d;
  logic [7:0]  samp_q, samp_d;
  logic [31:0] bytes_q, bytes_d;

  logic [15:0] len_w, len_trim, seg_eat;
  logic [11:0] cnt_inc, sym_sum;
  logic [7:0]  loop_dec;
  logic        comp_ok;

  always_comb begin
    len_w    = {hi_q, byte_i};
    len_trim = (len_w > 16'd2) ? len_w - 16'd2 : 16'd0;
    seg_eat  = (seg_q != 16'd0) ? seg_q - 16'd1 : 16'd0;
    cnt_inc  = cnt_q + 12'd1;
    sym_sum  = sym_q + {4'd0, byte_i};
    loop_dec = loop_q - 8'd1;
    comp_ok  = (comp_q >= 8'd1) && (comp_q <= 8'd3);
  end

  always_comb begin
    phase_d = phase_q; seg_d = seg_q; cnt_d = cnt_q; loop_d = loop_q;
    sym_d = sym_q; cls_d = cls_q; tbl_d = tbl_q; wide_d = wide_q;
    hi_d = hi_q; comp_d = comp_q; samp_d = samp_q;
    bytes_d = bytes_q + 32'd1;
    rec_valid_o = 1'b0;
    rec_o = '0;
    case (phase_q)
      PH_SOI: begin
        if (cnt_q == 12'd0) begin
          if (byte_i != MRK_PREFIX) begin
            rec_valid_o = 1'b1; rec_o.kind = KIND_ERROR;
            rec_o.error_code = ERR_NO_SOI; phase_d = PH_HALT;
          end else cnt_d = 12'd1;
        end else if (byte_i != MRK_SOI) begin
          rec_valid_o = 1'b1; rec_o.kind = KIND_ERROR;
          rec_o.error_code = ERR_NO_SOI; phase_d = PH_HALT;
        end else begin
          cnt_d = 12'd0; phase_d = PH_HUNT;
        end
      end
      PH_HUNT: if (byte_i == MRK_PREFIX) phase_d = PH_MARK;
      PH_MARK: begin
        cnt_d = 12'd0;
        if (byte_i == MRK_SOF0) phase_d = PH_SOF_HDR;
        else if (byte_i == MRK_DQT) phase_d = PH_DQT_L1;
        else if (byte_i == MRK_DHT) phase_d = PH_DHT_L1;
        else if (byte_i == MRK_SOS) phase_d = PH_SOS_HDR;
        else if (byte_i == MRK_EOI) begin
          rec_valid_o = 1'b1; rec_o.kind = KIND_ERROR;
          rec_o.error_code = ERR_EOI_FIRST; phase_d = PH_HALT;
        end else if (byte_i == MRK_DRI) phase_d = PH_DRI;
        else if (byte_i == MRK_PREFIX) phase_d = PH_MARK;
        else if (byte_i == 8'h00 || byte_i == 8'h01 ||
                 (byte_i >= MRK_RST0 && byte_i <= MRK_SOI)) phase_d = PH_HUNT;
        else phase_d = PH_SKIP_L1;
      end
      PH_SKIP_L1: begin hi_d = byte_i; phase_d = PH_SKIP_L2; end
      PH_SKIP_L2: begin
        seg_d = len_trim;
        phase_d = (len_trim != 16'd0) ? PH_SKIP : PH_HUNT;
      end
      PH_SKIP: begin
        seg_d = seg_eat;
        if (seg_eat == 16'd0) phase_d = PH_HUNT;
      end
      PH_SOF_HDR: begin
        if (cnt_q == 12'd3 || cnt_q == 12'd5) hi_d = byte_i;
        else if (cnt_q == 12'd4 || cnt_q == 12'd6) begin
          rec_valid_o = 1'b1;
          rec_o.kind = (cnt_q == 12'd4) ? KIND_HEIGHT : KIND_WIDTH;
          rec_o.value = len_w;
        end else if (cnt_q == 12'd7) begin
          if (byte_i > 8'd3) begin
            rec_valid_o = 1'b1; rec_o.kind = KIND_ERROR;
            rec_o.error_code = ERR_COMPS; phase_d = PH_HUNT;
          end else if (byte_i == 8'd0) phase_d = PH_HUNT;
          else begin loop_d = byte_i; phase_d = PH_SOF_CID; end
        end
        cnt_d = cnt_inc;
      end
      PH_SOF_CID:  begin comp_d = byte_i; phase_d = PH_SOF_SAMP; end
      PH_SOF_SAMP: begin samp_d = byte_i; phase_d = PH_SOF_TQ; end
      PH_SOF_TQ: begin
        if (comp_ok) begin
          rec_valid_o = 1'b1; rec_o.kind = KIND_COMP_SAMP;
          rec_o.component = 2'(comp_q - 8'd1);
          rec_o.value = {8'd0, byte_i};
          rec_o.h_factor = samp_q[7:4]; rec_o.v_factor = samp_q[3:0];
        end
        loop_d = loop_dec;
        phase_d = (loop_dec != 8'd0) ? PH_SOF_CID : PH_HUNT;
      end
      PH_DQT_L1, PH_DHT_L1: begin
        hi_d = byte_i;
        phase_d = (phase_q == PH_DQT_L1) ? PH_DQT_L2 : PH_DHT_L2;
      end
      PH_DQT_L2: begin
        seg_d = len_trim;
        phase_d = (len_trim != 16'd0) ? PH_DQT_PT : PH_HUNT;
      end
      PH_DHT_L2: begin
        seg_d = len_trim;
        phase_d = (len_trim != 16'd0) ? PH_DHT_TC : PH_HUNT;
      end
      PH_DQT_PT: begin
        seg_d = seg_eat;
        if (byte_i[3:2] != 2'd0) begin
          rec_valid_o = 1'b1; rec_o.kind = KIND_ERROR;
          rec_o.error_code = ERR_QUANT_IDX; phase_d = PH_HUNT;
        end else if (byte_i[7:5] != 3'd0) begin
          rec_valid_o = 1'b1; rec_o.kind = KIND_ERROR;
          rec_o.error_code = ERR_PRECISION; phase_d = PH_HUNT;
        end else begin
          tbl_d = byte_i[1:0]; wide_d = byte_i[4]; cnt_d = 12'd0;
          phase_d = byte_i[4] ? PH_DQT_VH : PH_DQT_V8;
        end
      end
      PH_DQT_VH: begin seg_d = seg_eat; hi_d = byte_i; phase_d = PH_DQT_VL; end
      PH_DQT_V8, PH_DQT_VL: begin
        seg_d = seg_eat;
        rec_valid_o = 1'b1; rec_o.kind = KIND_QUANT;
        rec_o.table_id = tbl_q; rec_o.entry_index = cnt_q;
        rec_o.value = (phase_q == PH_DQT_VL) ? len_w : {8'd0, byte_i};
        cnt_d = cnt_inc;
        if (cnt_inc >= QUANT_ENTRIES) phase_d = (seg_eat != 16'd0) ? PH_DQT_PT : PH_HUNT;
        else phase_d = wide_q ? PH_DQT_VH : PH_DQT_V8;
      end
      PH_DHT_TC: begin
        seg_d = seg_eat;
        if (byte_i[3:2] != 2'd0) begin
          rec_valid_o = 1'b1; rec_o.kind = KIND_ERROR;
          rec_o.error_code = ERR_HUFF_IDX; phase_d = PH_HUNT;
        end else if (byte_i[7:5] != 3'd0) begin
          rec_valid_o = 1'b1; rec_o.kind = KIND_ERROR;
          rec_o.error_code = ERR_CLASS; phase_d = PH_HUNT;
        end else begin
          cls_d = byte_i[4]; tbl_d = byte_i[1:0]; cnt_d = 12'd0; sym_d = 12'd0;
          phase_d = PH_DHT_CNT;
        end
      end
      PH_DHT_CNT: begin
        seg_d = seg_eat;
        rec_valid_o = 1'b1; rec_o.kind = KIND_HUFF_CNT;
        rec_o.table_class = cls_q; rec_o.table_id = tbl_q;
        rec_o.entry_index = cnt_q; rec_o.value = {8'd0, byte_i};
        sym_d = sym_sum; cnt_d = cnt_inc;
        if (cnt_inc >= HUFF_COUNTS) begin
          cnt_d = 12'd0;
          if (sym_sum == 12'd0) phase_d = (seg_eat != 16'd0) ? PH_DHT_TC : PH_HUNT;
          else phase_d = PH_DHT_SYM;
        end
      end
      PH_DHT_SYM: begin
        seg_d = seg_eat;
        rec_valid_o = 1'b1; rec_o.kind = KIND_HUFF_SYM;
        rec_o.table_class = cls_q; rec_o.table_id = tbl_q;
        rec_o.entry_index = cnt_q; rec_o.value = {8'd0, byte_i};
        cnt_d = cnt_inc;
        if (cnt_inc >= sym_q) phase_d = (seg_eat != 16'd0) ? PH_DHT_TC : PH_HUNT;
      end
      PH_SOS_HDR: begin
        if (cnt_q == 12'd2) begin
          rec_valid_o = 1'b1; rec_o.kind = KIND_SCAN_CNT;
          rec_o.value = {8'd0, byte_i};
          loop_d = byte_i; cnt_d = 12'd0;
          phase_d = (byte_i != 8'd0) ? PH_SOS_CID : PH_SOS_TAIL;
        end else cnt_d = cnt_inc;
      end
      PH_SOS_CID: begin comp_d = byte_i; phase_d = PH_SOS_TAB; end
      PH_SOS_TAB: begin
        if (comp_ok) begin
          rec_valid_o = 1'b1; rec_o.kind = KIND_SCAN_COMP;
          rec_o.component = 2'(comp_q - 8'd1);
          rec_o.dc_table = byte_i[7:4]; rec_o.ac_table = byte_i[3:0];
        end
        loop_d = loop_dec;
        if (loop_dec == 8'd0) begin cnt_d = 12'd0; phase_d = PH_SOS_TAIL; end
        else phase_d = PH_SOS_CID;
      end
      PH_SOS_TAIL: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= 12'd3) begin
          rec_valid_o = 1'b1; rec_o.kind = KIND_SCAN_START;
          rec_o.stream_offset = bytes_d; phase_d = PH_HALT;
        end
      end
      PH_DRI: begin
        if (cnt_q == 12'd2) hi_d = byte_i;
        if (cnt_q == 12'd3) begin
          rec_valid_o = 1'b1; rec_o.kind = KIND_RESTART;
          rec_o.value = len_w; phase_d = PH_HUNT;
        end
        cnt_d = cnt_inc;
      end
      PH_HALT: phase_d = PH_HALT;
      default: phase_d = PH_HALT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SOI; seg_q <= '0; cnt_q <= '0; loop_q <= '0; sym_q <= '0;
      cls_q <= 1'b0; tbl_q <= '0; wide_q <= 1'b0; hi_q <= '0; comp_q <= '0;
      samp_q <= '0; bytes_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d; seg_q <= seg_d; cnt_q <= cnt_d; loop_q <= loop_d;
      sym_q <= sym_d; cls_q <= cls_d; tbl_q <= tbl_d; wide_q <= wide_d;
      hi_q <= hi_d; comp_q <= comp_d; samp_q <= samp_d; bytes_q <= bytes_d;
    end
  end

endmodule

// ===== sv/jhmp_in_reg.sv =====
// Input byte register for the JPEG header parser.
// Depends on nothing beyond the clock and reset.
module jhmp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] data_i,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] data_o
);

  logic       valid_q;
  logic [7:0] data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_i;
  end

endmodule

// ===== sv/jpeg_header_marker_parser.sv =====
// Top level of the JPEG header marker parser.
// Depends on jhmp_pkg, jhmp_in_reg and jhmp_core.
//
// Usage:
//   Input channel: one file byte per beat on data_byte_i (valid_i/ready_o).
//   Output channel: one record per beat (valid_o/ready_i); each byte gives
//   zero or one record, fields not used by a kind are zero.
//   A byte passes an input register, then the parse logic updates the
//   parser state and loads the result register in the same cycle.
//   Throughput: one byte per cycle while the output is not stalled.
//   Stall: while a record waits in the result register, the parse stage
//   holds the byte in the input register, whether or not that byte gives
//   a record, and ready_o stays low until the record is taken.
//   Reset: parser waits for the SOI marker, byte count is zero.
//   After scan start, a bad SOI or an early EOI the parser halts and
//   accepts bytes without records until reset.
module jpeg_header_marker_parser import jhmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [3:0]  kind_o,
  output logic [1:0]  component_o,
  output logic        table_class_o,
  output logic [1:0]  table_id_o,
  output logic [11:0] entry_index_o,
  output logic [15:0] value_o,
  output logic [3:0]  h_factor_o,
  output logic [3:0]  v_factor_o,
  output logic [3:0]  dc_table_o,
  output logic [3:0]  ac_table_o,
  output logic [2:0]  error_code_o,
  output logic [31:0] stream_offset_o
);

  logic       byte_valid, step;
  logic [7:0] byte_q;
  logic       rec_valid;
  rec_t       rec, out_q;
  logic       out_valid_q;
  logic       out_free;

  assign out_free = !out_valid_q || ready_i;
  assign step     = byte_valid && out_free;

  jhmp_in_reg u_in (
    .clk_i, .rst_ni,
    .valid_i, .ready_o, .data_i(data_byte_i),
    .valid_o(byte_valid), .ready_i(out_free), .data_o(byte_q)
  );

  jhmp_core u_core (
    .clk_i, .rst_ni, .step_i(step), .byte_i(byte_q),
    .rec_valid_o(rec_valid), .rec_o(rec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && rec_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && rec_valid) out_q <= rec;
  end

  assign valid_o         = out_valid_q;
  assign kind_o          = out_q.kind;
  assign component_o     = out_q.component;
  assign table_class_o   = out_q.table_class;
  assign table_id_o      = out_q.table_id;
  assign entry_index_o   = out_q.entry_index;
  assign value_o         = out_q.value;
  assign h_factor_o      = out_q.h_factor;
  assign v_factor_o      = out_q.v_factor;
  assign dc_table_o      = out_q.dc_table;
  assign ac_table_o      = out_q.ac_table;
  assign error_code_o    = out_q.error_code;
  assign stream_offset_o = out_q.stream_offset;

endmodule

// ===== sv/jhmp_checker.sv =====
// Port-level checks for the JPEG header marker parser, bound to the top level.
// Depends on jhmp_pkg.
module jhmp_checker import jhmp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_o,
  input logic        ready_i,
  input logic [3:0]  kind_o,
  input logic [2:0]  error_code_o,
  input logic [3:0]  h_factor_o,
  input logic [31:0] stream_offset_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(kind_o))
    else $error("record dropped under stall");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> kind_o <= KIND_ERROR)
    else $error("kind out of range");

  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((kind_o == KIND_ERROR) == (error_code_o != 3'd0)))
    else $error("error code mismatch");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o != KIND_COMP_SAMP |-> h_factor_o == 4'd0)
    else $error("unused field not zero");

  a_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o == KIND_SCAN_START |-> stream_offset_o >= 32'd6)
    else $error("scan start offset too small");

endmodule

bind jpeg_header_marker_parser jhmp_checker u_jhmp_checker (
  .clk_i, .rst_ni, .valid_o, .ready_i, .kind_o, .error_code_o,
  .h_factor_o, .stream_offset_o
);

// ===== test/jpeg_header_marker_parser_checker.sv =====
// Checker for the JPEG header marker parser: predicts records from accepted bytes
// and compares each delivered record with the oldest prediction. Uses jhmp_pkg.
module jpeg_header_marker_parser_checker import jhmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  rec_t        out_rec_i,
  output int          fail_count_o,
  output int          pending_o
);

  phase_e      phase;
  logic [15:0] seg_left;
  logic [11:0] idx;
  logic [7:0]  loop_left;
  logic [11:0] sym_total;
  logic        cls;
  logic [1:0]  tbl;
  logic        wide;
  logic [7:0]  hold_hi;
  logic [7:0]  hold_comp;
  logic [7:0]  hold_samp;
  logic [31:0] nbytes;
  rec_t        rec;
  bit          got;
  rec_t        record_q[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o = record_q.size();

  task automatic emit(input logic [3:0] k);
    rec = '0;
    rec.kind = k;
    got = 1'b1;
  endtask

  task automatic raise(input logic [2:0] code, input bit halt);
    emit(KIND_ERROR);
    rec.error_code = code;
    phase = halt ? PH_HALT : PH_HUNT;
  endtask

  task automatic eat();
    if (seg_left != 0) seg_left = seg_left - 1;
  endtask

  task automatic take_length(input logic [7:0] b);
    logic [15:0] len;
    len = {hold_hi, b};
    seg_left = (len > 2) ? len - 16'd2 : 16'd0;
  endtask

  task automatic quant_entry(input logic [15:0] v);
    emit(KIND_QUANT);
    rec.table_id = tbl;
    rec.entry_index = idx;
    rec.value = v;
    idx = idx + 1;
    if (idx >= QUANT_ENTRIES) phase = (seg_left != 0) ? PH_DQT_PT : PH_HUNT;
    else phase = wide ? PH_DQT_VH : PH_DQT_V8;
  endtask

  task automatic huff_done();
    phase = (seg_left != 0) ? PH_DHT_TC : PH_HUNT;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    got = 1'b0;
    nbytes = nbytes + 1;
    case (phase)
      PH_SOI: begin
        if (idx == 0) begin
          if (b != MRK_PREFIX) raise(ERR_NO_SOI, 1); else idx = 1;
        end else if (b != MRK_SOI) begin
          raise(ERR_NO_SOI, 1);
        end else begin
          idx = 0;
          phase = PH_HUNT;
        end
      end
      PH_HUNT: if (b == MRK_PREFIX) phase = PH_MARK;
      PH_MARK: begin
        idx = 0;
        if (b == MRK_SOF0) phase = PH_SOF_HDR;
        else if (b == MRK_DQT) phase = PH_DQT_L1;
        else if (b == MRK_DHT) phase = PH_DHT_L1;
        else if (b == MRK_SOS) phase = PH_SOS_HDR;
        else if (b == MRK_EOI) raise(ERR_EOI_FIRST, 1);
        else if (b == MRK_DRI) phase = PH_DRI;
        else if (b == MRK_PREFIX) phase = PH_MARK;
        else if (b == 8'h00 || b == 8'h01 || (b >= MRK_RST0 && b <= MRK_SOI)) phase = PH_HUNT;
        else phase = PH_SKIP_L1;
      end
      PH_SKIP_L1: begin
        hold_hi = b;
        phase = PH_SKIP_L2;
      end
      PH_SKIP_L2: begin
        take_length(b);
        phase = (seg_left != 0) ? PH_SKIP : PH_HUNT;
      end
      PH_SKIP: begin
        eat();
        if (seg_left == 0) phase = PH_HUNT;
      end
      PH_SOF_HDR: begin
        if (idx == 3 || idx == 5) begin
          hold_hi = b;
        end else if (idx == 4 || idx == 6) begin
          emit(idx == 4 ? KIND_HEIGHT : KIND_WIDTH);
          rec.value = {hold_hi, b};
        end else if (idx == 7) begin
          if (b > 3) raise(ERR_COMPS, 0);
          else if (b == 0) phase = PH_HUNT;
          else begin
            loop_left = b;
            phase = PH_SOF_CID;
          end
        end
        idx = idx + 1;
      end
      PH_SOF_CID: begin
        hold_comp = b;
        phase = PH_SOF_SAMP;
      end
      PH_SOF_SAMP: begin
        hold_samp = b;
        phase = PH_SOF_TQ;
      end
      PH_SOF_TQ: begin
        if (hold_comp >= 1 && hold_comp <= 3) begin
          emit(KIND_COMP_SAMP);
          rec.component = 2'(hold_comp - 1);
          rec.value = {8'd0, b};
          rec.h_factor = hold_samp[7:4];
          rec.v_factor = hold_samp[3:0];
        end
        loop_left = loop_left - 1;
        phase = (loop_left != 0) ? PH_SOF_CID : PH_HUNT;
      end
      PH_DQT_L1, PH_DHT_L1: begin
        hold_hi = b;
        phase = (phase == PH_DQT_L1) ? PH_DQT_L2 : PH_DHT_L2;
      end
      PH_DQT_L2: begin
        take_length(b);
        phase = (seg_left != 0) ? PH_DQT_PT : PH_HUNT;
      end
      PH_DQT_PT: begin
        eat();
        if (b[3:0] >= 4) raise(ERR_QUANT_IDX, 0);
        else if (b[7:4] > 1) raise(ERR_PRECISION, 0);
        else begin
          tbl = b[1:0];
          wide = b[4];
          idx = 0;
          phase = wide ? PH_DQT_VH : PH_DQT_V8;
        end
      end
      PH_DQT_V8: begin
        eat();
        quant_entry({8'd0, b});
      end
      PH_DQT_VH: begin
        eat();
        hold_hi = b;
        phase = PH_DQT_VL;
      end
      PH_DQT_VL: begin
        eat();
        quant_entry({hold_hi, b});
      end
      PH_DHT_L2: begin
        take_length(b);
        phase = (seg_left != 0) ? PH_DHT_TC : PH_HUNT;
      end
      PH_DHT_TC: begin
        eat();
        if (b[3:0] >= 4) raise(ERR_HUFF_IDX, 0);
        else if (b[7:4] > 1) raise(ERR_CLASS, 0);
        else begin
          cls = b[4];
          tbl = b[1:0];
          idx = 0;
          sym_total = 0;
          phase = PH_DHT_CNT;
        end
      end
      PH_DHT_CNT, PH_DHT_SYM: begin
        eat();
        emit(phase == PH_DHT_CNT ? KIND_HUFF_CNT : KIND_HUFF_SYM);
        rec.table_class = cls;
        rec.table_id = tbl;
        rec.entry_index = idx;
        rec.value = {8'd0, b};
        idx = idx + 1;
        if (phase == PH_DHT_CNT) begin
          sym_total = sym_total + b;
          if (idx >= HUFF_COUNTS) begin
            idx = 0;
            if (sym_total == 0) huff_done(); else phase = PH_DHT_SYM;
          end
        end else if (idx >= sym_total) begin
          huff_done();
        end
      end
      PH_SOS_HDR: begin
        if (idx == 2) begin
          emit(KIND_SCAN_CNT);
          rec.value = {8'd0, b};
          loop_left = b;
          idx = 0;
          phase = (b != 0) ? PH_SOS_CID : PH_SOS_TAIL;
        end else begin
          idx = idx + 1;
        end
      end
      PH_SOS_CID: begin
        hold_comp = b;
        phase = PH_SOS_TAB;
      end
      PH_SOS_TAB: begin
        if (hold_comp >= 1 && hold_comp <= 3) begin
          emit(KIND_SCAN_COMP);
          rec.component = 2'(hold_comp - 1);
          rec.dc_table = b[7:4];
          rec.ac_table = b[3:0];
        end
        loop_left = loop_left - 1;
        if (loop_left == 0) begin
          idx = 0;
          phase = PH_SOS_TAIL;
        end else begin
          phase = PH_SOS_CID;
        end
      end
      PH_SOS_TAIL: begin
        idx = idx + 1;
        if (idx >= 3) begin
          emit(KIND_SCAN_START);
          rec.stream_offset = nbytes;
          phase = PH_HALT;
        end
      end
      PH_DRI: begin
        if (idx == 2) hold_hi = b;
        if (idx == 3) begin
          emit(KIND_RESTART);
          rec.value = {hold_hi, b};
          phase = PH_HUNT;
        end
        idx = idx + 1;
      end
      default: phase = PH_HALT;
    endcase
  endtask

  task automatic mismatch(input string what, input logic [31:0] e, input logic [31:0] a);
    fails++;
    if (fails <= 10) $display("mismatch %s: expected %0h, got %0h", what, e, a);
  endtask

  task automatic compare_record(input rec_t e, input rec_t a);
    if (e.kind !== a.kind) mismatch("kind", e.kind, a.kind);
    if (e.component !== a.component) mismatch("component", e.component, a.component);
    if (e.table_class !== a.table_class) mismatch("table_class", e.table_class, a.table_class);
    if (e.table_id !== a.table_id) mismatch("table_id", e.table_id, a.table_id);
    if (e.entry_index !== a.entry_index) mismatch("entry_index", e.entry_index, a.entry_index);
    if (e.value !== a.value) mismatch("value", e.value, a.value);
    if (e.h_factor !== a.h_factor) mismatch("h_factor", e.h_factor, a.h_factor);
    if (e.v_factor !== a.v_factor) mismatch("v_factor", e.v_factor, a.v_factor);
    if (e.dc_table !== a.dc_table) mismatch("dc_table", e.dc_table, a.dc_table);
    if (e.ac_table !== a.ac_table) mismatch("ac_table", e.ac_table, a.ac_table);
    if (e.error_code !== a.error_code) mismatch("error_code", e.error_code, a.error_code);
    if (e.stream_offset !== a.stream_offset)
      mismatch("stream_offset", e.stream_offset, a.stream_offset);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase = PH_SOI;
      seg_left = '0;
      idx = '0;
      loop_left = '0;
      sym_total = '0;
      cls = 1'b0;
      tbl = '0;
      wide = 1'b0;
      hold_hi = '0;
      hold_comp = '0;
      hold_samp = '0;
      nbytes = '0;
      record_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (record_q.size() == 0) begin
          mismatch("unexpected record, kind", 32'hx, out_rec_i.kind);
        end else begin
          compare_record(record_q[0], out_rec_i);
          void'(record_q.pop_front());
        end
      end
      if (in_valid_i && in_ready_i) begin
        parse_byte(in_byte_i);
        if (got) record_q.push_back(rec);
      end
    end
  end

  initial fails = 0;

endmodule

// ===== test/jpeg_header_marker_parser_test.sv =====
// Testbench top for the JPEG header marker parser: builds a byte stream of
// random header segments, drives it with random gaps and stalls, gives the verdict.
// Depends on jhmp_pkg, jpeg_header_marker_parser and jpeg_header_marker_parser_checker.
module jpeg_header_marker_parser_test import jhmp_pkg::*;;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic [7:0]  data_byte_i = 8'd0;
  logic        ready_i = 1'b0;
  logic        ready_o;
  logic        valid_o;
  logic [3:0]  kind_o;
  logic [1:0]  component_o;
  logic        table_class_o;
  logic [1:0]  table_id_o;
  logic [11:0] entry_index_o;
  logic [15:0] value_o;
  logic [3:0]  h_factor_o;
  logic [3:0]  v_factor_o;
  logic [3:0]  dc_table_o;
  logic [3:0]  ac_table_o;
  logic [2:0]  error_code_o;
  logic [31:0] stream_offset_o;
  rec_t        out_rec;
  int          fail_count;
  int          pending;
  logic [7:0]  file_q[$];
  int          sent;
  int          stall_cycles;
  bit          calm;

  assign out_rec = {kind_o, component_o, table_class_o, table_id_o, entry_index_o, value_o,
                    h_factor_o, v_factor_o, dc_table_o, ac_table_o, error_code_o,
                    stream_offset_o};

  jpeg_header_marker_parser i_dut (.*);

  jpeg_header_marker_parser_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i(valid_i), .in_ready_i(ready_o), .in_byte_i(data_byte_i),
    .out_valid_i(valid_o), .out_ready_i(ready_i), .out_rec_i(out_rec),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic put(input logic [7:0] b);
    file_q.push_back(b);
  endtask

  task automatic put16(input logic [15:0] w);
    put(w[15:8]);
    put(w[7:0]);
  endtask

  function automatic logic [7:0] noise_byte();
    return 8'($urandom_range(254));
  endfunction

  task automatic add_quant(input int ntab, input bit shorten, input bit wide_only);
    int n16[4];
    int len;
    len = 2;
    for (int t = 0; t < ntab; t++) begin
      n16[t] = wide_only ? 1 : ($urandom_range(3) == 0);
      len += 1 + 64 * (1 + n16[t]);
    end
    put(MRK_PREFIX);
    put(MRK_DQT);
    put16(shorten ? 16'($urandom_range(len - 1)) : 16'(len));
    for (int t = 0; t < ntab; t++) begin
      put({3'd0, 1'(n16[t]), 2'd0, 2'($urandom_range(3))});
      for (int i = 0; i < 64; i++) begin
        if (n16[t] != 0) put16(16'($urandom));
        else put(8'($urandom));
      end
    end
  endtask

  task automatic add_huff(input int ntab, input bit shorten, input bit big_count);
    int cnt[16];
    int total;
    logic [7:0] sym_q[$];
    sym_q.delete();
    for (int t = 0; t < ntab; t++) begin
      total = 0;
      sym_q.push_back({3'd0, 1'($urandom), 2'd0, 2'($urandom_range(3))});
      for (int i = 0; i < 16; i++) begin
        cnt[i] = ($urandom_range(2) == 0) ? $urandom_range(3) : 0;
        if (big_count && i == 15) cnt[i] = 255;
        total += cnt[i];
        sym_q.push_back(8'(cnt[i]));
      end
      for (int i = 0; i < total; i++) sym_q.push_back(8'($urandom));
    end
    put(MRK_PREFIX);
    put(MRK_DHT);
    put16(shorten ? 16'($urandom_range(sym_q.size() + 1)) : 16'(sym_q.size() + 2));
    foreach (sym_q[i]) put(sym_q[i]);
  endtask

  task automatic add_frame(input int ncomp);
    put(MRK_PREFIX);
    put(MRK_SOF0);
    put16(16'($urandom));
    put(8'($urandom));
    put16(16'($urandom));
    put16(16'($urandom));
    put(8'(ncomp));
    if (ncomp <= 3) begin
      for (int c = 0; c < ncomp; c++) begin
        put(($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(1, 3)));
        put(8'($urandom));
        put(8'($urandom));
      end
    end
  endtask

  task automatic add_restart(input logic [15:0] interval);
    put(MRK_PREFIX);
    put(MRK_DRI);
    put16(16'($urandom));
    put16(interval);
  endtask

  task automatic add_skip(input logic [7:0] mrk, input int len);
    put(MRK_PREFIX);
    put(mrk);
    put16(16'(len));
    for (int i = 2; i < len; i++) put(8'($urandom));
  endtask

  task automatic add_bad_table(input logic [7:0] mrk, input bit bad_index);
    put(MRK_PREFIX);
    put(mrk);
    put16(16'($urandom_range(3, 200)));
    if (bad_index) put({4'($urandom), 4'($urandom_range(4, 15))});
    else put({4'($urandom_range(2, 15)), 2'd0, 2'($urandom_range(3))});
  endtask

  task automatic add_scan(input int ncomp);
    put(MRK_PREFIX);
    put(MRK_SOS);
    put16(16'($urandom));
    put(8'(ncomp));
    for (int c = 0; c < ncomp; c++) begin
      put(($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(1, 3)));
      put(8'($urandom));
    end
    put(8'h00);
    put(8'h3F);
    put(8'h00);
  endtask

  task automatic build_file();
    logic [7:0] mrk;
    put(MRK_PREFIX);
    put(MRK_SOI);
    put(8'h00);
    put(MRK_PREFIX);
    put(MRK_PREFIX);
    put(8'h01);
    put(MRK_PREFIX);
    put(MRK_RST0);
    put(MRK_PREFIX);
    put(MRK_SOI);
    add_skip(8'hE0, 1);
    add_restart(16'hFFFF);
    add_restart(16'h0000);
    add_frame(0);
    add_frame(4);
    add_bad_table(MRK_DQT, 1);
    add_bad_table(MRK_DQT, 0);
    add_bad_table(MRK_DHT, 1);
    add_bad_table(MRK_DHT, 0);
    add_quant(1, 0, 1);
    add_huff(1, 0, 1);
    while (file_q.size() < 1000) begin
      case ($urandom_range(9))
        0, 1: add_quant($urandom_range(1, 2), $urandom_range(3) == 0, 0);
        2, 3: add_huff($urandom_range(1, 2), $urandom_range(3) == 0, 0);
        4: add_frame(($urandom_range(5) == 0) ? $urandom_range(4, 255) : $urandom_range(3));
        5: add_restart(16'($urandom));
        6: begin
          do mrk = 8'($urandom_range(2, 254));
          while (mrk inside {MRK_SOF0, MRK_DQT, MRK_DHT, MRK_SOS, MRK_EOI, MRK_DRI} ||
                 (mrk >= MRK_RST0 && mrk <= MRK_SOI));
          add_skip(mrk, $urandom_range(0, 12));
        end
        7: begin
          put(MRK_PREFIX);
          if ($urandom_range(1)) put(MRK_PREFIX);
          put(8'($urandom_range(MRK_RST0, MRK_SOI)));
        end
        8: add_bad_table(($urandom_range(1)) ? MRK_DQT : MRK_DHT, $urandom_range(1));
        default: repeat ($urandom_range(1, 6)) put(noise_byte());
      endcase
    end
    add_scan($urandom_range(4));
    repeat (5) put(8'($urandom));
  endtask

  always @(posedge clk_i) begin
    ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 16);
  end

  always @(posedge clk_i) begin
    if ((valid_i && ready_o) || (valid_o && ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= 5000) begin
      $display("jpeg_header_marker_parser_test NOT OK");
      $finish;
    end
  end

  initial begin
    bit held_off;
    int pause_at;
    stall_cycles = 0;
    calm = 1'b0;
    sent = 0;
    held_off = 1'b0;
    build_file();
    pause_at = file_q.size() / 2;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (sent < file_q.size()) begin
      @(posedge clk_i);
      if (valid_i && ready_o) sent++;
      calm = (sent >= 300 && sent < 500);
      if (sent >= file_q.size()) break;
      if (valid_i && !ready_o) continue;
      if (sent == pause_at && !held_off) begin
        valid_i <= 1'b0;
        if (pending == 0 && !valid_i) held_off = 1'b1;
      end else if (calm || $urandom_range(99) >= 16) begin
        valid_i <= 1'b1;
        data_byte_i <= file_q[sent];
      end else begin
        valid_i <= 1'b0;
      end
    end
    valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("jpeg_header_marker_parser_test OK");
    end else begin
      $display("jpeg_header_marker_parser_test NOT OK");
    end
    $finish;
  end

endmodule
